// ===== design/blm_pkg.sv =====
// ----------------------------------------------------------------------------
// blm_pkg: shared types, constants and fixed-point helpers
// Q16.48 saturating arithmetic used by the line minimizer and its units.
// ----------------------------------------------------------------------------
package blm_pkg;

  // Fraction bits of the signed fixed-point format.
  localparam int unsigned FracBits = 48;

  typedef logic signed [63:0] fxp_t;

  localparam fxp_t FxpMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fxp_t FxpMin = 64'sh8000_0000_0000_0000;

  // Golden-section fraction 0.3819660, rounded to FracBits fraction bits.
  localparam logic [63:0] GoldQ60 = 64'd440376815428658912;
  localparam logic [63:0] GoldRaw = (GoldQ60 + (64'd1 << (59 - FracBits)))
                                    >> (60 - FracBits);
  localparam fxp_t GoldStep = fxp_t'(GoldRaw);

  // Configuration register indexes and reset values.
  localparam logic [1:0] CfgRelTol  = 2'd0;
  localparam logic [1:0] CfgAbsTol  = 2'd1;
  localparam logic [1:0] CfgMaxIter = 2'd2;

  localparam logic [48:0] RelTolReset  = 49'd28147497671;
  localparam logic [32:0] AbsTolReset  = 33'd28147;
  localparam logic [7:0]  MaxIterReset = 8'd100;

  // Field codes.
  localparam logic       CmdStart   = 1'b0;
  localparam logic       CmdValue   = 1'b1;
  localparam logic       KindQuery  = 1'b0;
  localparam logic       KindDone   = 1'b1;
  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatFail   = 2'd1;
  localparam logic [1:0] StatIdle   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_PROBE
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_UPD,
    S_ITER,
    S_TMUL,
    S_TOL2,
    S_TEST,
    S_RMUL,
    S_QMUL,
    S_P1MUL,
    S_P2MUL,
    S_QFIX,
    S_C1MUL,
    S_C2MUL,
    S_C3MUL,
    S_DIV,
    S_ADJ,
    S_GOLD,
    S_GMUL,
    S_PROBE
  } state_e;

  typedef struct packed {
    logic              command;
    logic signed [63:0] bracket_one;
    logic signed [63:0] first_guess;
    logic signed [63:0] bracket_two;
    logic signed [63:0] target_value;
    logic signed [63:0] func_value;
    logic              eval_ok;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic signed [63:0] query_x;
    logic signed [63:0] best_x;
    logic signed [63:0] best_f;
    logic [1:0]        status;
  } rsp_t;

  // Saturating add.
  function automatic fxp_t sat_add(fxp_t a, fxp_t b);
    fxp_t s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      return a[63] ? FxpMin : FxpMax;
    end
    return s;
  endfunction

  // Saturating subtract.
  function automatic fxp_t sat_sub(fxp_t a, fxp_t b);
    fxp_t s;
    s = a - b;
    if ((a[63] != b[63]) && (s[63] != a[63])) begin
      return a[63] ? FxpMin : FxpMax;
    end
    return s;
  endfunction

  function automatic fxp_t sat_neg(fxp_t a);
    return (a == FxpMin) ? FxpMax : -a;
  endfunction

  function automatic fxp_t sat_abs(fxp_t a);
    return a[63] ? sat_neg(a) : a;
  endfunction

  function automatic fxp_t half(fxp_t a);
    return a >>> 1;
  endfunction

  // Exact floor of the mean of two values.
  function automatic fxp_t midpoint(fxp_t a, fxp_t b);
    return half(a) + half(b) + fxp_t'({63'd0, a[0] & b[0]});
  endfunction

  // Magnitude of a with the sign of b applied.
  function automatic fxp_t sign_of(fxp_t a, fxp_t b);
    return b[63] ? sat_neg(sat_abs(a)) : sat_abs(a);
  endfunction

  function automatic logic [63:0] mag(fxp_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // Saturated signed value from a magnitude, a sign and an overflow flag.
  function automatic fxp_t signed_mag(logic [63:0] m, logic neg, logic ovf);
    if (neg) begin
      if (ovf || (m > 64'h8000_0000_0000_0000)) begin
        return FxpMin;
      end
      return fxp_t'(-m);
    end
    if (ovf || m[63]) begin
      return FxpMax;
    end
    return fxp_t'(m);
  endfunction

endpackage

// ===== design/blm_mul.sv =====
// ----------------------------------------------------------------------------
// blm_mul: shared fixed-point multiplier
// Forms the 128-bit magnitude product from four 32x32 partial products, one
// per cycle, then scales and saturates it.
// ----------------------------------------------------------------------------
module blm_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  blm_pkg::fxp_t       a_i,
  input  blm_pkg::fxp_t       b_i,
  output logic                done_o,
  output blm_pkg::fxp_t       res_o
);

  logic [63:0]  ua_q, ua_d, ub_q, ub_d;
  logic         neg_q, neg_d;
  logic [127:0] acc_q, acc_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d, fin_q, fin_d;

  logic [31:0]  a_part, b_part;
  logic [63:0]  prod;
  logic [127:0] prod_sh;

  // One partial product per cycle, selected by the pass counter.
  always_comb begin
    a_part = cnt_q[0] ? ua_q[63:32] : ua_q[31:0];
    b_part = cnt_q[1] ? ub_q[63:32] : ub_q[31:0];
    prod   = {32'd0, a_part} * {32'd0, b_part};
    unique case ({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]})
      2'd0:    prod_sh = {64'd0, prod};
      2'd1:    prod_sh = {32'd0, prod, 32'd0};
      default: prod_sh = {prod, 64'd0};
    endcase
  end

  // Pass sequencing.
  always_comb begin
    ua_d   = ua_q;
    ub_d   = ub_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    fin_d  = 1'b0;
    if (start_i) begin
      ua_d   = blm_pkg::mag(a_i);
      ub_d   = blm_pkg::mag(b_i);
      neg_d  = a_i[63] ^ b_i[63];
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + prod_sh;
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q  <= ua_d;
    ub_q  <= ub_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
  end

  // Scale by the fraction width and saturate.
  assign done_o = fin_q;
  assign res_o  = blm_pkg::signed_mag(acc_q[blm_pkg::FracBits +: 64], neg_q,
                                      |acc_q[127:blm_pkg::FracBits + 64]);

endmodule

// ===== design/blm_div.sv =====
// ----------------------------------------------------------------------------
// blm_div: fixed-point divider
// Restoring division of the scaled magnitude, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module blm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  blm_pkg::fxp_t       p_i,
  input  blm_pkg::fxp_t       q_i,
  output logic                done_o,
  output blm_pkg::fxp_t       res_o
);

  logic [127:0] num_q, num_d;
  logic [63:0]  den_q, den_d, rem_q, rem_d, quo_q, quo_d;
  logic         ovf_q, ovf_d, neg_q, neg_d, zero_q, zero_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d, fin_q, fin_d;
  logic [64:0]  rem_sh;

  // Shift in one dividend bit and try to subtract the divisor.
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    fin_d  = 1'b0;
    rem_sh = {rem_q, num_q[127]};
    if (start_i) begin
      num_d  = {64'd0, blm_pkg::mag(p_i)} << blm_pkg::FracBits;
      den_d  = blm_pkg::mag(q_i);
      rem_d  = '0;
      quo_d  = '0;
      ovf_d  = 1'b0;
      zero_d = (q_i == '0);
      neg_d  = (q_i == '0) ? p_i[63] : (p_i[63] ^ q_i[63]);
      cnt_d  = '0;
      busy_d = (q_i != '0);
      fin_d  = (q_i == '0);
    end else if (busy_q) begin
      num_d = num_q << 1;
      ovf_d = ovf_q | quo_q[63];
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = 64'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = rem_sh[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd127) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  // A zero divisor saturates toward the dividend's sign.
  assign done_o = fin_q;
  assign res_o  = zero_q ? (neg_q ? blm_pkg::FxpMin : blm_pkg::FxpMax)
                         : blm_pkg::signed_mag(quo_q, neg_q, ovf_q);

endmodule

// ===== design/brent_line_minimizer_top.sv =====
// ----------------------------------------------------------------------------
// brent_line_minimizer_top: Brent line minimizer sequencer
// Plans golden-section and parabolic probes for an outside evaluator.
// ----------------------------------------------------------------------------
// A start request is registered, sorted in the dispatch state and answered by a
// probe at the first guess in the output register; a reply while idle or a
// failed evaluation is answered from the dispatch state in the same way. A good
// function value is processed by a sequencer that runs saturating Q16.48
// operations step by step and shares one multiplier (four 32x32 passes per
// product) and one divider (one quotient bit a cycle). A parabolic step that
// passes its checks ends in a division. The request input is stalled from
// acceptance until its answer is placed in the output register; the user must
// write configuration only while no search step is in progress, and the block
// itself does not enforce it.
module brent_line_minimizer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  blm_pkg::req_t       in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output blm_pkg::rsp_t       out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [48:0]         cfg_data_i
);

  blm_pkg::state_e state_q, state_d;
  blm_pkg::phase_e phase_q, phase_d;

  logic [48:0] rel_q;
  logic [32:0] abs_q;
  logic [7:0]  maxit_q;

  blm_pkg::fxp_t a_q, a_d, b_q, b_d, x_q, x_d, w_q, w_d, v_q, v_d;
  blm_pkg::fxp_t fx_q, fx_d, fw_q, fw_d, fv_q, fv_d;
  blm_pkg::fxp_t d_q, d_d, e_q, e_d, u_q, u_d, tgt_q, tgt_d;
  blm_pkg::fxp_t tol1_q, tol1_d, tol2_q, tol2_d, xm_q, xm_d, hw_q, hw_d;
  blm_pkg::fxp_t r_q, r_d, qq_q, qq_d, p_q, p_d, et_q, et_d;
  logic [7:0]    iter_q, iter_d;
  logic          rej_q, rej_d;

  blm_pkg::req_t in_q, in_d;
  blm_pkg::rsp_t out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic          mul_start, mul_done, mul_pend_q, mul_pend_d;
  blm_pkg::fxp_t mul_a, mul_b, mul_res;
  logic          div_start, div_done, div_pend_q, div_pend_d;
  blm_pkg::fxp_t div_res;

  logic          emit_ok;
  logic          in_take;

  assign in_take    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != blm_pkg::S_IDLE);
  assign emit_ok    = !out_valid_q || !out_stall_i;

  // Shared arithmetic units.
  blm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  blm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .p_i     (p_q),
    .q_i     (qq_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // Sequencer: next state, datapath updates and result emission.
  always_comb begin
    blm_pkg::fxp_t t0;
    blm_pkg::fxp_t t1;
    blm_pkg::fxp_t fu;

    state_d = state_q;
    phase_d = phase_q;
    a_d = a_q;   b_d = b_q;   x_d = x_q;   w_d = w_q;   v_d = v_q;
    fx_d = fx_q; fw_d = fw_q; fv_d = fv_q;
    d_d = d_q;   e_d = e_q;   u_d = u_q;   tgt_d = tgt_q;
    tol1_d = tol1_q; tol2_d = tol2_q; xm_d = xm_q; hw_d = hw_q;
    r_d = r_q;   qq_d = qq_q; p_d = p_q;   et_d = et_q;
    iter_d = iter_q;
    rej_d  = rej_q;
    in_d   = in_take ? in_req_i : in_q;
    out_d  = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    t0 = '0;
    t1 = '0;
    fu = in_q.func_value;

    unique case (state_q)
      blm_pkg::S_IDLE: begin
        if (in_take) begin
          state_d = blm_pkg::S_DISP;
        end
      end

      // Sort the request by command and phase.
      blm_pkg::S_DISP: begin
        if (in_q.command == blm_pkg::CmdStart) begin
          if (emit_ok) begin
            if (in_q.bracket_one < in_q.bracket_two) begin
              a_d = in_q.bracket_one;
              b_d = in_q.bracket_two;
            end else begin
              a_d = in_q.bracket_two;
              b_d = in_q.bracket_one;
            end
            x_d = in_q.first_guess; w_d = in_q.first_guess; v_d = in_q.first_guess;
            fx_d = '0; fw_d = '0; fv_d = '0;
            d_d = '0; e_d = '0;
            u_d = in_q.first_guess;
            tgt_d = in_q.target_value;
            iter_d = '0;
            phase_d = blm_pkg::PH_FIRST;
            out_d = '{blm_pkg::KindQuery, in_q.first_guess, '0, '0, blm_pkg::StatOk};
            out_valid_d = 1'b1;
            state_d = blm_pkg::S_IDLE;
          end
        end else if (phase_q == blm_pkg::PH_IDLE) begin
          if (emit_ok) begin
            out_d = '{blm_pkg::KindDone, '0, '0, '0, blm_pkg::StatIdle};
            out_valid_d = 1'b1;
            state_d = blm_pkg::S_IDLE;
          end
        end else if (!in_q.eval_ok) begin
          if (emit_ok) begin
            out_d = '{blm_pkg::KindDone, '0, '0, '0, blm_pkg::StatFail};
            out_valid_d = 1'b1;
            phase_d = blm_pkg::PH_IDLE;
            state_d = blm_pkg::S_IDLE;
          end
        end else if (phase_q == blm_pkg::PH_FIRST) begin
          fx_d = fu; fw_d = fu; fv_d = fu;
          iter_d = 8'd1;
          state_d = blm_pkg::S_TMUL;
        end else begin
          state_d = blm_pkg::S_UPD;
        end
      end

      // Fold the probe value into the bracket and the three best points, or finish once it falls below the target.
      blm_pkg::S_UPD: begin
        if (fu <= fx_q) begin
          if (fu < tgt_q) begin
            if (emit_ok) begin
              out_d = '{blm_pkg::KindDone, '0, u_q, fu, blm_pkg::StatOk};
              out_valid_d = 1'b1;
              phase_d = blm_pkg::PH_IDLE;
              state_d = blm_pkg::S_IDLE;
            end
          end else begin
            if (u_q >= x_q) a_d = x_q; else b_d = x_q;
            v_d = w_q;   w_d = x_q;   x_d = u_q;
            fv_d = fw_q; fw_d = fx_q; fx_d = fu;
            state_d = blm_pkg::S_ITER;
          end
        end else begin
          if (u_q < x_q) a_d = u_q; else b_d = u_q;
          if ((fu <= fw_q) || (w_q == x_q)) begin
            v_d = w_q;   w_d = u_q;
            fv_d = fw_q; fw_d = fu;
          end else if ((fu <= fv_q) || (v_q == x_q) || (v_q == w_q)) begin
            v_d = u_q;
            fv_d = fu;
          end
          state_d = blm_pkg::S_ITER;
        end
      end

      // Iteration cap ends the search with the current best.
      blm_pkg::S_ITER: begin
        if (iter_q >= maxit_q) begin
          if (emit_ok) begin
            out_d = '{blm_pkg::KindDone, '0, x_q, fx_q, blm_pkg::StatOk};
            out_valid_d = 1'b1;
            phase_d = blm_pkg::PH_IDLE;
            state_d = blm_pkg::S_IDLE;
          end
        end else begin
          iter_d = iter_q + 8'd1;
          state_d = blm_pkg::S_TMUL;
        end
      end

      // Tolerance: relative part times |x| plus the absolute part.
      blm_pkg::S_TMUL: begin
        mul_a = blm_pkg::fxp_t'({15'd0, rel_q});
        mul_b = blm_pkg::sat_abs(x_q);
        mul_start = !mul_pend_q;
        if (mul_done) begin
          tol1_d = blm_pkg::sat_add(mul_res, blm_pkg::fxp_t'({31'd0, abs_q}));
          xm_d   = blm_pkg::midpoint(a_q, b_q);
          state_d = blm_pkg::S_TOL2;
        end
      end

      blm_pkg::S_TOL2: begin
        tol2_d = blm_pkg::sat_add(tol1_q, tol1_q);
        hw_d   = blm_pkg::half(blm_pkg::sat_sub(b_q, a_q));
        state_d = blm_pkg::S_TEST;
      end

      // Convergence test, then choose parabolic or golden step.
      blm_pkg::S_TEST: begin
        t0 = blm_pkg::sat_abs(blm_pkg::sat_sub(x_q, xm_q));
        t1 = blm_pkg::sat_sub(tol2_q, hw_q);
        if (t0 <= t1) begin
          if (emit_ok) begin
            out_d = '{blm_pkg::KindDone, '0, x_q, fx_q, blm_pkg::StatOk};
            out_valid_d = 1'b1;
            phase_d = blm_pkg::PH_IDLE;
            state_d = blm_pkg::S_IDLE;
          end
        end else if (blm_pkg::sat_abs(e_q) > tol1_q) begin
          state_d = blm_pkg::S_RMUL;
        end else begin
          state_d = blm_pkg::S_GOLD;
        end
      end

      blm_pkg::S_RMUL: begin
        mul_a = blm_pkg::sat_sub(x_q, w_q);
        mul_b = blm_pkg::sat_sub(fx_q, fv_q);
        mul_start = !mul_pend_q;
        if (mul_done) begin
          r_d = mul_res;
          state_d = blm_pkg::S_QMUL;
        end
      end

      blm_pkg::S_QMUL: begin
        mul_a = blm_pkg::sat_sub(x_q, v_q);
        mul_b = blm_pkg::sat_sub(fx_q, fw_q);
        mul_start = !mul_pend_q;
        if (mul_done) begin
          qq_d = mul_res;
          state_d = blm_pkg::S_P1MUL;
        end
      end

      blm_pkg::S_P1MUL: begin
        mul_a = blm_pkg::sat_sub(x_q, v_q);
        mul_b = qq_q;
        mul_start = !mul_pend_q;
        if (mul_done) begin
          p_d = mul_res;
          state_d = blm_pkg::S_P2MUL;
        end
      end

      blm_pkg::S_P2MUL: begin
        mul_a = blm_pkg::sat_sub(x_q, w_q);
        mul_b = r_q;
        mul_start = !mul_pend_q;
        if (mul_done) begin
          p_d = blm_pkg::sat_sub(p_q, mul_res);
          state_d = blm_pkg::S_QFIX;
        end
      end

      // Normalize the parabola so that the denominator is not negative.
      blm_pkg::S_QFIX: begin
        t0 = blm_pkg::sat_sub(qq_q, r_q);
        t1 = blm_pkg::sat_add(t0, t0);
        if (t1 > 0) p_d = blm_pkg::sat_neg(p_q);
        qq_d = blm_pkg::sat_abs(t1);
        et_d = e_q;
        e_d  = d_q;
        state_d = blm_pkg::S_C1MUL;
      end

      // Reject a step that is too long or that leaves the bracket.
      blm_pkg::S_C1MUL: begin
        mul_a = blm_pkg::half(qq_q);
        mul_b = et_q;
        mul_start = !mul_pend_q;
        if (mul_done) begin
          rej_d = (blm_pkg::sat_abs(p_q) >= blm_pkg::sat_abs(mul_res));
          state_d = blm_pkg::S_C2MUL;
        end
      end

      blm_pkg::S_C2MUL: begin
        mul_a = qq_q;
        mul_b = blm_pkg::sat_sub(a_q, x_q);
        mul_start = !mul_pend_q;
        if (mul_done) begin
          if (rej_q || (p_q <= mul_res)) state_d = blm_pkg::S_GOLD;
          else state_d = blm_pkg::S_C3MUL;
        end
      end

      blm_pkg::S_C3MUL: begin
        mul_a = qq_q;
        mul_b = blm_pkg::sat_sub(b_q, x_q);
        mul_start = !mul_pend_q;
        if (mul_done) begin
          if (p_q >= mul_res) state_d = blm_pkg::S_GOLD;
          else state_d = blm_pkg::S_DIV;
        end
      end

      // Parabolic step p / q.
      blm_pkg::S_DIV: begin
        div_start = !div_pend_q;
        if (div_done) begin
          d_d = div_res;
          state_d = blm_pkg::S_ADJ;
        end
      end

      // Keep a parabolic probe away from the bracket ends.
      blm_pkg::S_ADJ: begin
        t0 = blm_pkg::sat_add(x_q, d_q);
        if ((blm_pkg::sat_sub(t0, a_q) < tol2_q) || (blm_pkg::sat_sub(b_q, t0) < tol2_q)) begin
          d_d = blm_pkg::sign_of(tol1_q, blm_pkg::sat_sub(xm_q, x_q));
        end
        state_d = blm_pkg::S_PROBE;
      end

      // Golden section into the larger half.
      blm_pkg::S_GOLD: begin
        e_d = (x_q >= xm_q) ? blm_pkg::sat_sub(a_q, x_q) : blm_pkg::sat_sub(b_q, x_q);
        state_d = blm_pkg::S_GMUL;
      end

      blm_pkg::S_GMUL: begin
        mul_a = blm_pkg::GoldStep;
        mul_b = e_q;
        mul_start = !mul_pend_q;
        if (mul_done) begin
          d_d = mul_res;
          state_d = blm_pkg::S_PROBE;
        end
      end

      // Place the probe at least one tolerance away and request it.
      blm_pkg::S_PROBE: begin
        if (blm_pkg::sat_abs(d_q) >= tol1_q) t0 = blm_pkg::sat_add(x_q, d_q);
        else t0 = blm_pkg::sat_add(x_q, blm_pkg::sign_of(tol1_q, d_q));
        if (emit_ok) begin
          u_d = t0;
          phase_d = blm_pkg::PH_PROBE;
          out_d = '{blm_pkg::KindQuery, t0, '0, '0, blm_pkg::StatOk};
          out_valid_d = 1'b1;
          state_d = blm_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = blm_pkg::S_IDLE;
      end
    endcase

    mul_pend_d = (mul_pend_q || mul_start) && !mul_done;
    div_pend_d = (div_pend_q || div_start) && !div_done;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blm_pkg::S_IDLE;
      phase_q     <= blm_pkg::PH_IDLE;
      out_valid_q <= 1'b0;
      mul_pend_q  <= 1'b0;
      div_pend_q  <= 1'b0;
      iter_q      <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      mul_pend_q  <= mul_pend_d;
      div_pend_q  <= div_pend_d;
      iter_q      <= iter_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_q   <= blm_pkg::RelTolReset;
      abs_q   <= blm_pkg::AbsTolReset;
      maxit_q <= blm_pkg::MaxIterReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == blm_pkg::CfgRelTol) rel_q <= cfg_data_i;
      if (cfg_idx_i == blm_pkg::CfgAbsTol) abs_q <= cfg_data_i[32:0];
      if (cfg_idx_i == blm_pkg::CfgMaxIter) maxit_q <= cfg_data_i[7:0];
    end
  end

  // Search state and payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; b_q <= '0; x_q <= '0; w_q <= '0; v_q <= '0;
      fx_q <= '0; fw_q <= '0; fv_q <= '0;
      d_q <= '0; e_q <= '0; u_q <= '0; tgt_q <= '0;
    end else begin
      a_q <= a_d; b_q <= b_d; x_q <= x_d; w_q <= w_d; v_q <= v_d;
      fx_q <= fx_d; fw_q <= fw_d; fv_q <= fv_d;
      d_q <= d_d; e_q <= e_d; u_q <= u_d; tgt_q <= tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tol1_q <= tol1_d; tol2_q <= tol2_d; xm_q <= xm_d; hw_q <= hw_d;
    r_q <= r_d; qq_q <= qq_d; p_q <= p_d; et_q <= et_d;
    rej_q <= rej_d;
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // The multiplier and the divider are never in use at once.
  a_units_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_pend_q && div_pend_q))
    else $error("multiplier and divider both pending");

  // An accepted request is dispatched in the next cycle.
  a_take_disp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q == blm_pkg::S_DISP))
    else $error("accepted request not dispatched");

  // A finished result leaves no search running.
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == blm_pkg::KindDone)) |-> (phase_q == blm_pkg::PH_IDLE))
    else $error("search still running after finish");

  // A unit result only arrives for a pending operation.
  a_mul_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> mul_pend_q)
    else $error("unexpected multiplier result");

endmodule
